@@ hw/rtl/c3fw_pkg.sv @@
package c3fw_pkg;

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int OUT_W   = 14;
  localparam int SIZE_W  = 11;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = PIX_W + 1 + COEF_W;
  localparam int ROW_W   = PROD_W + 2;
  localparam int SUM_W   = ROW_W + 2;
  localparam int FRAC_W  = 14;

  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;
  localparam int QCW     = 3;

  localparam logic [IDX_W-1:0] REG_IMAGE_SIZE = 2'd0;
  localparam logic [IDX_W-1:0] REG_K_TOP      = 2'd1;
  localparam logic [IDX_W-1:0] REG_K_MID      = 2'd2;
  localparam logic [IDX_W-1:0] REG_K_BOT      = 2'd3;

  localparam logic [CFG_W-1:0] K_TOP_RST = 48'd0;
  localparam logic [CFG_W-1:0] K_MID_RST = 48'd16384;
  localparam logic [CFG_W-1:0] K_BOT_RST = 48'd0;

  localparam logic [SIZE_W-1:0] SIZE_MIN = 11'd3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;
  typedef logic [2:0][CFG_W-1:0] kern_t;

  typedef struct packed {
    win_t win;
    logic wide;
    logic frame_end;
  } job_t;

  typedef struct packed {
    logic last;
    logic done;
  } res_tag_t;

  typedef struct packed {
    win_t     win;
    logic [1:0] start;
    res_tag_t tag;
  } res_req_t;

endpackage

@@ hw/rtl/c3fw_line_mem.sv @@
module c3fw_line_mem
  import c3fw_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [2*PIX_W-1:0]   rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [2*PIX_W-1:0]   wr_data
);

  // word: [15:8] previous row, [7:0] row before it
  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/c3fw_job_queue.sv @@
module c3fw_job_queue
  import c3fw_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  job_t           push_job,
  output logic [QCW-1:0] count,
  output logic           req_valid,
  output res_req_t       req,
  input  logic           req_ready
);

  job_t           q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic [1:0]     k_r, k_nxt;
  logic           issue, pop;
  job_t           head;

  assign head      = q_r[rp_r];
  assign req_valid = (cnt_r != '0);
  assign issue     = req_valid && req_ready;
  assign pop       = issue && req.tag.last;

  always_comb begin
    req.win      = head.win;
    req.start    = k_r;
    req.tag.last = !head.wide || (k_r == 2'd2);
    req.tag.done = head.wide && head.frame_end && (k_r == 2'd2);
  end

  always_comb begin
    cnt_nxt = cnt_r + QCW'(push) - QCW'(pop);
    k_nxt   = k_r;
    if (issue) begin
      k_nxt = pop ? 2'd0 : k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      k_r   <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      cnt_r <= cnt_nxt;
      k_r   <= k_nxt;
    end
  end

  assign count = cnt_r;

endmodule

@@ hw/rtl/c3fw_mac.sv @@
module c3fw_mac
  import c3fw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_valid,
  input  res_req_t                req,
  output logic                    req_ready,
  input  kern_t                   kern,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] pixel_out,
  output logic                    last,
  output logic                    done
);

  logic                      en;

  logic signed [COEF_W-1:0]  coef [3][3];
  logic signed [PROD_W-1:0]  prod_nxt [3][3];
  logic signed [PROD_W-1:0]  a_prod_r [3][3];
  logic                      a_valid_r;
  res_tag_t                  a_tag_r;

  logic signed [ROW_W-1:0]   row_nxt [3];
  logic signed [ROW_W-1:0]   b_row_r [3];
  logic                      b_valid_r;
  res_tag_t                  b_tag_r;

  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   biased;
  logic signed [SUM_W-1:0]   quot;
  logic signed [OUT_W-1:0]   pix_nxt;
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   pix_r;
  res_tag_t                  tag_r;

  assign en        = !out_valid_r || out_ready;
  assign req_ready = en;

  // window column p takes kernel tap p - start, none left of start
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int p = 0; p < 3; p++) begin
        coef[i][p] = '0;
        if (p >= int'(req.start)) begin
          coef[i][p] = kern[i][COEF_W*(p - int'(req.start)) +: COEF_W];
        end
        prod_nxt[i][p] = $signed({1'b0, req.win[i][p]}) * coef[i][p];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_nxt[i] = ROW_W'(a_prod_r[i][0]) + ROW_W'(a_prod_r[i][1])
                 + ROW_W'(a_prod_r[i][2]);
    end
  end

  always_comb begin
    total  = SUM_W'(b_row_r[0]) + SUM_W'(b_row_r[1]) + SUM_W'(b_row_r[2]);
    biased = total + SUM_W'(1 << (FRAC_W - 1));
    quot   = biased >>> FRAC_W;
    if (quot > SUM_W'((1 << (OUT_W - 1)) - 1)) begin
      pix_nxt = OUT_W'((1 << (OUT_W - 1)) - 1);
    end else if (quot < -SUM_W'(1 << (OUT_W - 1))) begin
      pix_nxt = OUT_W'(1 << (OUT_W - 1));
    end else begin
      pix_nxt = quot[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= prod_nxt;
      a_tag_r  <= req.tag;
      b_row_r  <= row_nxt;
      b_tag_r  <= a_tag_r;
      pix_r    <= pix_nxt;
      tag_r    <= b_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= req_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign pixel_out = pix_r;
  assign last      = tag_r.last;
  assign done      = tag_r.done;

endmodule

@@ hw/rtl/conv3x3_forward_window_unit.sv @@
// 3x3 forward-window correlation, line stores in one RAM; one request per cycle while in_ready is high.
// A last-column request yields three results, absorbed by the next row's first two
// columns. With an idle queue the first result of an accepted request passes through the
// RAM read, the window update and queue push, and the three MAC stages before it is valid.
// Reset: counters, window, queue and pipeline clear; image size 3, middle-row left tap 1.0.
// The line RAM is not cleared; its unwritten words are only read in the first two rows.
module conv3x3_forward_window_unit
  import c3fw_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [PIX_W-1:0]        in_pixel_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_pixel_out,
  output logic                    out_last_in_run,
  output logic                    out_frame_done,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_WIDTH + 2);

  logic [NW-1:0]    n_r;
  kern_t            kern_r;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  win_t             win_r, win_nxt;

  logic [SIZE_W-1:0] size_in;
  logic [NW-1:0]     size_clamped;
  logic              size_wr;

  logic              in_fire;
  logic [RW-1:0]     n_e, col_e;
  logic              last_col, row_end;
  pix_t              pix_v;

  logic              s1_valid_r;
  pix_t              s1_v_r;
  logic [CW-1:0]     s1_addr_r;
  logic              s1_emit_r, s1_wide_r, s1_end_r;

  logic [2*PIX_W-1:0] mem_rd;
  pix_t               mem_top, mem_mid;

  logic [QCW-1:0]    q_cnt;
  logic [QCW:0]      occ;
  job_t              job;
  logic              req_valid, req_ready;
  res_req_t          req;

  // configuration
  assign size_in = cfg_wdata[SIZE_W-1:0];
  assign size_wr = cfg_we && (cfg_index == REG_IMAGE_SIZE);

  always_comb begin
    if (size_in < SIZE_MIN) begin
      size_clamped = NW'(SIZE_MIN);
    end else if (32'(size_in) > MAX_WIDTH) begin
      size_clamped = NW'(MAX_WIDTH);
    end else begin
      size_clamped = NW'(size_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= NW'(SIZE_MIN);
      kern_r[0] <= K_TOP_RST;
      kern_r[1] <= K_MID_RST;
      kern_r[2] <= K_BOT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_SIZE: n_r       <= size_clamped;
        REG_K_TOP:      kern_r[0] <= cfg_wdata;
        REG_K_MID:      kern_r[1] <= cfg_wdata;
        REG_K_BOT:      kern_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stream position
  assign occ      = {1'b0, q_cnt} + (QCW+1)'(s1_valid_r);
  assign in_ready = occ < (QCW+1)'(QDEPTH);
  assign in_fire  = in_valid && in_ready;

  assign n_e      = RW'(n_r);
  assign col_e    = RW'(col_r);
  assign last_col = (col_e + RW'(1)) == n_e;
  assign row_end  = row_r == (n_e + RW'(1));
  assign pix_v    = (!in_action && (row_r < n_e)) ? in_pixel_in : '0;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (size_wr) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line RAM stage; consecutive requests never share an address (n >= 3),
  // so the write-back lands before any later read of the same word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_v_r    <= pix_v;
      s1_addr_r <= col_r;
      s1_emit_r <= (row_r >= RW'(2)) && (col_r >= CW'(2));
      s1_wide_r <= last_col;
      s1_end_r  <= row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  c3fw_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (mem_rd),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data ({s1_v_r, mem_mid})
  );

  assign mem_mid = mem_rd[2*PIX_W-1:PIX_W];
  assign mem_top = mem_rd[PIX_W-1:0];

  // window
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = mem_top;
    win_nxt[1][2] = mem_mid;
    win_nxt[2][2] = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (size_wr) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  assign job.win       = win_nxt;
  assign job.wide      = s1_wide_r;
  assign job.frame_end = s1_end_r;

  c3fw_job_queue u_job_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && s1_emit_r),
    .push_job  (job),
    .count     (q_cnt),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  c3fw_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .kern      (kern_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (out_pixel_out),
    .last      (out_last_in_run),
    .done      (out_frame_done)
  );

endmodule

@@ bench/conv3x3_forward_window_unit_test.sv @@
module conv3x3_forward_window_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import c3fw_pkg::*;

  localparam int LINE_MAX      = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 380;
  localparam int WIDE_BURST    = 8;

  // hand-picked frame at n = 3: pixel extremes, drain items inside the frame,
  // pixel items in the drain rows
  localparam logic DIR_ACT [15] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam pix_t DIR_PIX [15] = '{8'd255, 8'd0, 8'd255, 8'd77, 8'd255, 8'd0,
                                    8'd128, 8'd1, 8'd254, 8'd200, 8'd0, 8'd13,
                                    8'd0, 8'd99, 8'd255};

  class conv_window_predictor;
    typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic                    last;
      logic                    done;
    } sum_t;

    int unsigned      side;
    logic [CFG_W-1:0] kern [3];
    pix_t             prev_row [LINE_MAX];
    pix_t             older_row [LINE_MAX];
    pix_t             win [3][3];
    int unsigned      row;
    int unsigned      col;
    sum_t             expected_sums [$];
    int               fails;

    function new();
      side    = SIZE_MIN;
      kern[0] = K_TOP_RST;
      kern[1] = K_MID_RST;
      kern[2] = K_BOT_RST;
      fails   = 0;
      foreach (prev_row[i]) begin
        prev_row[i]  = '0;
        older_row[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      row = 0;
      col = 0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      int unsigned n;
      case (idx)
        REG_IMAGE_SIZE: begin
          n = val[SIZE_W-1:0];
          if (n < SIZE_MIN) n = SIZE_MIN;
          if (n > LINE_MAX) n = LINE_MAX;
          side = n;
          restart();
        end
        REG_K_TOP: kern[0] = val;
        REG_K_MID: kern[1] = val;
        REG_K_BOT: kern[2] = val;
        default: ;
      endcase
    endfunction

    // window whose left edge sits at window column 'first'; taps past column 2 are cut
    function logic signed [OUT_W-1:0] window_sum(int unsigned first);
      longint                   acc;
      longint                   q;
      logic signed [COEF_W-1:0] tap;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        for (int unsigned j = 0; first + j <= 2; j++) begin
          tap = kern[i][COEF_W*j +: COEF_W];
          acc += longint'(win[i][first+j]) * longint'(tap);
        end
      end
      q = (acc + 8192) >>> FRAC_W;
      if (q > 8191) q = 8191;
      if (q < -8192) q = -8192;
      return q[OUT_W-1:0];
    endfunction

    function void note_request(logic act, pix_t px);
      pix_t        v;
      pix_t        top;
      pix_t        mid;
      int unsigned runs;
      v   = (!act && row < side) ? px : '0;
      top = older_row[col];
      mid = prev_row[col];
      older_row[col] = mid;
      prev_row[col]  = v;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = v;
      if (row >= 2 && col >= 2) begin
        runs = (col + 1 >= side) ? 3 : 1;
        for (int unsigned k = 0; k < runs; k++) begin
          expected_sums.push_back('{window_sum(k), k == runs - 1,
                                    (k == runs - 1) && runs == 3 && row == side + 1});
        end
      end
      if (col + 1 >= side) begin
        col = 0;
        row = (row + 1 >= side + 2) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void check_result(logic signed [OUT_W-1:0] value, logic last, logic done);
      sum_t want;
      if (expected_sums.size() == 0) begin
        $error("unexpected result: pixel_out %0d last_in_run %0b frame_done %0b",
               value, last, done);
        fails++;
        return;
      end
      want = expected_sums.pop_front();
      if (value !== want.value) begin
        $error("pixel_out: expected %0d, got %0d", want.value, value);
        fails++;
      end
      if (last !== want.last) begin
        $error("last_in_run: expected %0b, got %0b", want.last, last);
        fails++;
      end
      if (done !== want.done) begin
        $error("frame_done: expected %0b, got %0b", want.done, done);
        fails++;
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_action;
  pix_t                    in_pixel_in;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_pixel_out;
  logic                    out_last_in_run;
  logic                    out_frame_done;
  logic                    cfg_we;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;

  int                   idle_pct  = 0;
  int                   stall_pct = 0;
  int unsigned          sent      = 0;
  conv_window_predictor model     = new();

  conv3x3_forward_window_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_out   (out_pixel_out),
    .out_last_in_run (out_last_in_run),
    .out_frame_done  (out_frame_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) model.note_request(in_action, in_pixel_in);
      if (out_valid && out_ready) model.check_result(out_pixel_out, out_last_in_run,
                                                     out_frame_done);
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic push_item(input logic act, input pix_t px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] size_word, input logic [CFG_W-1:0] top,
                           input logic [CFG_W-1:0] mid, input logic [CFG_W-1:0] bot);
    logic [IDX_W-1:0] which [4];
    logic [CFG_W-1:0] word [4];
    which = '{REG_IMAGE_SIZE, REG_K_TOP, REG_K_MID, REG_K_BOT};
    word  = '{size_word, top, mid, bot};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= which[i];
      cfg_wdata <= word[i];
      @(posedge clk);
      model.write_reg(which[i], word[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed_frame();
    for (int i = 0; i < 15; i++) push_item(DIR_ACT[i], DIR_PIX[i]);
  endtask

  function automatic logic [CFG_W-1:0] rand_kernel_row();
    logic [CFG_W-1:0] r;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(3))
        0: r[COEF_W*j +: COEF_W] = '0;
        1: r[COEF_W*j +: COEF_W] = COEF_W'(int'($urandom_range(8191)) - 4096);
        default: r[COEF_W*j +: COEF_W] = COEF_W'($urandom);
      endcase
    end
    return r;
  endfunction

  // random upper bits: only the low size bits count
  function automatic logic [CFG_W-1:0] size_word(int unsigned code);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    raw[SIZE_W-1:0] = SIZE_W'(code);
    return raw[CFG_W-1:0];
  endfunction

  initial begin
    int unsigned frame_no;
    int unsigned side_now;
    int unsigned total;
    int unsigned cut;
    int unsigned n_code;
    logic        act;
    logic        must_config;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= 1'b0;
    in_pixel_in <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_IMAGE_SIZE;
    cfg_wdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration, then saturated taps with a too-small size
    run_directed_frame();
    configure(size_word(0), {3{16'h7fff}}, {3{16'h8000}}, {16'h7fff, 16'h8000, 16'h0001});
    run_directed_frame();

    // oversized write clamps to the widest line; a short burst stays in row 0
    configure(size_word(2047), rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    for (int i = 0; i < WIDE_BURST; i++) push_item(1'b0, pix_t'($urandom));

    frame_no    = 0;
    side_now    = LINE_MAX;
    must_config = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      case (frame_no % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      if (must_config || $urandom_range(99) < 70) begin
        case ($urandom_range(19))
          0, 1, 2: side_now = $urandom_range(10, 7);
          3: side_now = 12;
          default: side_now = $urandom_range(6, 3);
        endcase
        n_code = (side_now == 3 && $urandom_range(1)) ? $urandom_range(2) : side_now;
        configure(size_word(n_code), rand_kernel_row(), rand_kernel_row(),
                  rand_kernel_row());
      end
      total       = side_now * (side_now + 2);
      cut         = ($urandom_range(99) < 15) ? $urandom_range(total - 1, 1) : total;
      must_config = (cut < total);
      for (int unsigned k = 0; k < cut; k++) begin
        if (k / side_now < side_now) act = ($urandom_range(99) < 6);
        else act = ($urandom_range(99) < 85);
        push_item(act, pix_t'($urandom));
        if (frame_no % 5 == 2 && k == total / 2) wait_drained();
      end
      frame_no++;
    end

    wait_drained();
    if (model.fails == 0) begin
      $display("PASS conv3x3_forward_window_unit");
    end else begin
      $display("FAIL conv3x3_forward_window_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL conv3x3_forward_window_unit");
    $finish;
  end

endmodule

@@ conv3x3_forward_window_unit.f @@
hw/rtl/c3fw_pkg.sv
hw/rtl/c3fw_line_mem.sv
hw/rtl/c3fw_job_queue.sv
hw/rtl/c3fw_mac.sv
hw/rtl/conv3x3_forward_window_unit.sv
bench/conv3x3_forward_window_unit_test.sv
